// File: rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg: shared types and constants of the grid local maxima finder
// Grid limits, field widths, register indexes and the command bundle that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package glmf_pkg;

    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_PEAKS   = 63;
    localparam int SAMPLE_BITS = 32;

    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_MAX     = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int DIM_W       = $clog2(DIM_MAX + 1);
    localparam int POS_W       = 8;
    localparam int CNT_W       = 6;
    localparam int M3_W        = SAMPLE_BITS + 2;

    // Register indexes on the configuration port.
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic              restart;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
        logic              cap_edge;
        logic              cap_vert;
        logic              eval;
        logic              emit_end;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_cmd;

endpackage

// File: rtl/grid_local_maxima_finder.sv
// ----------------------------------------------------------------------------
// grid_local_maxima_finder: four-neighbor peak detector over a stored grid
// Loads a grid of signed samples, then reports each interior cell (up to
// MAX_PEAKS of them) that is no smaller than its four neighbors and above
// three quarters of the grid maximum, then one end beat with the count.
// ----------------------------------------------------------------------------
// Usage: while o_busy is low, each cycle with i_start high takes one sample
// beat, row-major, until a grid of cols x rows samples is loaded. The beat
// that completes the grid raises o_busy for the scan, which primes the
// window at the start of each interior row and then tests one interior
// cell at a time, paced by the two read ports of the sample store.
// Results come out as single-cycle beats on o_result_valid and cannot be
// held off, so the receiver must take every beat as it appears. The last
// beat of a scan has o_end_marker set and carries the number of peaks
// reported and an overflow flag; o_busy is already low in that cycle and a
// new grid may start. Writing either size register restarts the grid load.
// ----------------------------------------------------------------------------
module grid_local_maxima_finder import glmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Sample input.
    input  logic             i_start,
    input  t_sample          i_sample,
    output logic             o_busy,
    // Result output.
    output logic             o_result_valid,
    output logic [POS_W-1:0] o_peak_row,
    output logic [POS_W-1:0] o_peak_col,
    output t_sample          o_peak_value,
    output logic             o_end_marker,
    output logic [CNT_W-1:0] o_peak_count,
    output logic             o_overflow,
    // Configuration port.
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [DIM_W-1:0] r_cols, n_cols;
    logic [DIM_W-1:0] r_rows, n_rows;
    logic             cfg_wr;
    logic             reg_sel;
    logic             ctrl_busy;
    t_cmd             cmd;

    // Sizes are clamped on write so the rest of the design sees legal values.
    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_W'(3)) begin
            res = DIM_W'(3);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    // The register index is the word address; the byte offset is ignored.
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cols = r_cols;
        n_rows = r_rows;
        if (cfg_wr) begin
            case (reg_sel)
                REG_COLS: n_cols = f_clamp(pwdata[DIM_W-1:0], DIM_W'(MAX_COLS));
                REG_ROWS: n_rows = f_clamp(pwdata[DIM_W-1:0], DIM_W'(MAX_ROWS));
                default:  n_cols = r_cols;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_COLS: prdata = 32'(r_cols);
            REG_ROWS: prdata = 32'(r_rows);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= DIM_W'(MAX_COLS);
            r_rows <= DIM_W'(MAX_ROWS);
        end else begin
            r_cols <= n_cols;
            r_rows <= n_rows;
        end
    end

    glmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cfg_wr (cfg_wr),
        .i_cols   (r_cols),
        .i_rows   (r_rows),
        .o_busy   (ctrl_busy),
        .o_cmd    (cmd)
    );

    glmf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .o_peak_row     (o_peak_row),
        .o_peak_col     (o_peak_col),
        .o_peak_value   (o_peak_value),
        .o_end_marker   (o_end_marker),
        .o_peak_count   (o_peak_count),
        .o_overflow     (o_overflow)
    );

    assign o_busy = ctrl_busy;

    // Every result beat follows a cycle of scanning.
    a_beat_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(ctrl_busy))
        else $error("result beat without a preceding scan cycle");

    // The end beat coincides with the return to the load phase.
    a_end_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_end_marker) |-> !ctrl_busy)
        else $error("block still busy during end beat");

    // Peak beats only ever name interior cells.
    a_peak_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_end_marker) |-> (o_peak_row != '0 && o_peak_col != '0))
        else $error("peak beat on a border cell");

    // Overflow is only reported once the peak budget is used up.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_end_marker && o_overflow) |->
            (o_peak_count == CNT_W'(MAX_PEAKS)))
        else $error("overflow flagged with peak budget not exhausted");

endmodule

// File: rtl/glmf_ram.sv
// ----------------------------------------------------------------------------
// glmf_ram: generic RAM, one write port and two registered read ports
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module glmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// File: rtl/glmf_ctrl.sv
// ----------------------------------------------------------------------------
// glmf_ctrl: load and scan sequencer of the grid local maxima finder
// Counts incoming samples, then walks the interior cells and issues the
// store reads and evaluation commands for each one.
// ----------------------------------------------------------------------------
module glmf_ctrl import glmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_cfg_wr,
    input  logic [DIM_W-1:0] i_cols,
    input  logic [DIM_W-1:0] i_rows,
    output logic             o_busy,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_VERT  = 3'd2;
    localparam logic [2:0] S_RIGHT = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_load_idx, n_load_idx;
    logic [POS_W-1:0]  r_load_col, n_load_col;
    logic [POS_W-1:0]  r_load_row, n_load_row;
    logic [POS_W-1:0]  r_row,      n_row;
    logic [POS_W-1:0]  r_col,      n_col;
    logic [ADDR_W-1:0] r_idx,      n_idx;

    logic [ADDR_W-1:0] width_a;
    logic              load_last_col;
    logic              load_last_row;
    logic              scan_last_col;
    logic              scan_last_row;

    assign width_a       = ADDR_W'(i_cols);
    assign load_last_col = ({1'b0, r_load_col} == (i_cols - DIM_W'(1)));
    assign load_last_row = ({1'b0, r_load_row} == (i_rows - DIM_W'(1)));
    assign scan_last_col = ({1'b0, r_col} == (i_cols - DIM_W'(2)));
    assign scan_last_row = ({1'b0, r_row} == (i_rows - DIM_W'(2)));
    assign o_busy        = (r_state != S_LOAD);

    always_comb begin
        n_state    = r_state;
        n_load_idx = r_load_idx;
        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_row      = r_row;
        n_col      = r_col;
        n_idx      = r_idx;

        o_cmd          = '0;
        o_cmd.restart  = i_cfg_wr;
        o_cmd.wr_addr  = r_load_idx;
        o_cmd.row      = r_row;
        o_cmd.col      = r_col;

        case (r_state)
            S_LOAD: begin
                if (i_cfg_wr) begin
                    n_load_idx = '0;
                    n_load_col = '0;
                    n_load_row = '0;
                    if (i_start) begin
                        // A sample taken with a register write opens the new grid.
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_addr = '0;
                        n_load_idx    = ADDR_W'(1);
                        n_load_col    = POS_W'(1);
                    end
                end else if (i_start) begin
                    o_cmd.wr_en = 1'b1;
                    if (load_last_col && load_last_row) begin
                        // Whole grid is in; first interior cell is (1, 1).
                        n_load_idx = '0;
                        n_load_col = '0;
                        n_load_row = '0;
                        n_row      = POS_W'(1);
                        n_col      = POS_W'(1);
                        n_idx      = width_a + ADDR_W'(1);
                        n_state    = S_ROW;
                    end else begin
                        n_load_idx = r_load_idx + ADDR_W'(1);
                        if (load_last_col) begin
                            n_load_col = '0;
                            n_load_row = r_load_row + POS_W'(1);
                        end else begin
                            n_load_col = r_load_col + POS_W'(1);
                        end
                    end
                end
            end
            S_ROW: begin
                o_cmd.rd_addr0 = r_idx - ADDR_W'(1);
                o_cmd.rd_addr1 = r_idx;
                n_state        = S_VERT;
            end
            S_VERT: begin
                o_cmd.cap_edge = 1'b1;
                o_cmd.rd_addr0 = r_idx - width_a;
                o_cmd.rd_addr1 = r_idx + width_a;
                n_state        = S_RIGHT;
            end
            S_RIGHT: begin
                o_cmd.cap_vert = 1'b1;
                o_cmd.rd_addr0 = r_idx + ADDR_W'(1);
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!scan_last_col) begin
                    // Fetch the vertical neighbors of the next cell now.
                    o_cmd.rd_addr0 = r_idx + ADDR_W'(1) - width_a;
                    o_cmd.rd_addr1 = r_idx + ADDR_W'(1) + width_a;
                    n_col          = r_col + POS_W'(1);
                    n_idx          = r_idx + ADDR_W'(1);
                    n_state        = S_RIGHT;
                end else if (!scan_last_row) begin
                    n_row   = r_row + POS_W'(1);
                    n_col   = POS_W'(1);
                    n_idx   = r_idx + ADDR_W'(3);
                    n_state = S_ROW;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                o_cmd.emit_end = 1'b1;
                n_state        = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_idx <= '0;
            r_load_col <= '0;
            r_load_row <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_idx <= n_load_idx;
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_row      <= n_row;
            r_col      <= n_col;
            r_idx      <= n_idx;
        end
    end

endmodule

// File: rtl/glmf_dpath.sv
// ----------------------------------------------------------------------------
// glmf_dpath: sample store, maximum tracking and peak test
// Holds the grid, the five-cell window of the scan, the peak counter and
// the result registers.
// ----------------------------------------------------------------------------
module glmf_dpath import glmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_sample          i_sample,
    output logic             o_result_valid,
    output logic [POS_W-1:0] o_peak_row,
    output logic [POS_W-1:0] o_peak_col,
    output t_sample          o_peak_value,
    output logic             o_end_marker,
    output logic [CNT_W-1:0] o_peak_count,
    output logic             o_overflow
);

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] rdata0;
    logic [SAMPLE_BITS-1:0] rdata1;

    t_sample               r_max,    n_max;
    logic signed [M3_W-1:0] r_max3;
    t_sample               r_left, r_center, r_up, r_dn;
    logic [CNT_W-1:0]      r_found,  n_found;
    logic                  r_ovf,    n_ovf;
    logic                  r_valid,  n_valid;
    logic [POS_W-1:0]      r_row_o,  n_row_o;
    logic [POS_W-1:0]      r_col_o,  n_col_o;
    t_sample               r_val_o,  n_val_o;
    logic                  r_end_o,  n_end_o;
    logic [CNT_W-1:0]      r_cnt_o,  n_cnt_o;
    logic                  r_ovf_o,  n_ovf_o;

    t_sample                right;
    logic signed [M3_W-1:0] center_x4;
    logic signed [M3_W-1:0] max_x3;
    logic                   is_peak;

    glmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (i_cmd.wr_en),
        .i_waddr  (i_cmd.wr_addr),
        .i_wdata  (i_sample),
        .i_raddr0 (i_cmd.rd_addr0),
        .i_raddr1 (i_cmd.rd_addr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    assign right     = t_sample'(rdata0);
    assign center_x4 = {r_center, 2'b00};
    assign max_x3    = M3_W'(r_max) + {r_max[SAMPLE_BITS-1], r_max, 1'b0};

    // Ties with a neighbor still count; the threshold is 4*v > 3*max exactly.
    assign is_peak = !(r_center < r_left) && !(r_center < right) &&
                     !(r_center < r_up) && !(r_center < r_dn) &&
                     (center_x4 > r_max3);

    always_comb begin
        n_max = (i_cmd.restart || i_cmd.emit_end) ? SAMPLE_MIN : r_max;
        if (i_cmd.wr_en && (i_sample > n_max)) begin
            n_max = i_sample;
        end

        n_found = r_found;
        n_ovf   = r_ovf;
        n_valid = 1'b0;
        n_row_o = r_row_o;
        n_col_o = r_col_o;
        n_val_o = r_val_o;
        n_end_o = r_end_o;
        n_cnt_o = r_cnt_o;
        n_ovf_o = r_ovf_o;

        if (i_cmd.eval && is_peak) begin
            if (r_found < CNT_W'(MAX_PEAKS)) begin
                n_valid = 1'b1;
                n_row_o = i_cmd.row;
                n_col_o = i_cmd.col;
                n_val_o = r_center;
                n_end_o = 1'b0;
                n_cnt_o = '0;
                n_ovf_o = 1'b0;
                n_found = r_found + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.emit_end) begin
            n_valid = 1'b1;
            n_row_o = '0;
            n_col_o = '0;
            n_val_o = '0;
            n_end_o = 1'b1;
            n_cnt_o = r_found;
            n_ovf_o = r_ovf;
            n_found = '0;
            n_ovf   = 1'b0;
        end

        if (i_cmd.restart) begin
            n_found = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= SAMPLE_MIN;
            r_found <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_max   <= n_max;
            r_found <= n_found;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max3  <= max_x3;
        r_row_o <= n_row_o;
        r_col_o <= n_col_o;
        r_val_o <= n_val_o;
        r_end_o <= n_end_o;
        r_cnt_o <= n_cnt_o;
        r_ovf_o <= n_ovf_o;
        if (i_cmd.cap_edge) begin
            r_left   <= t_sample'(rdata0);
            r_center <= t_sample'(rdata1);
        end
        if (i_cmd.cap_vert) begin
            r_up <= t_sample'(rdata0);
            r_dn <= t_sample'(rdata1);
        end
        if (i_cmd.eval) begin
            r_left   <= r_center;
            r_center <= right;
        end
    end

    assign o_result_valid = r_valid;
    assign o_peak_row     = r_row_o;
    assign o_peak_col     = r_col_o;
    assign o_peak_value   = r_val_o;
    assign o_end_marker   = r_end_o;
    assign o_peak_count   = r_cnt_o;
    assign o_overflow     = r_ovf_o;

endmodule

// File: tb/sv/grid_local_maxima_finder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_local_maxima_finder_chk: result checker for the grid peak finder
// Watches the sample, configuration and result channels. It keeps its own
// copy of the grid and the size registers, works out the peak beats and the
// end beat that each completed grid must produce, and compares every result
// beat field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module grid_local_maxima_finder_chk import glmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_sample          i_sample,
    input  logic             o_busy,
    input  logic             o_result_valid,
    input  logic [POS_W-1:0] o_peak_row,
    input  logic [POS_W-1:0] o_peak_col,
    input  t_sample          o_peak_value,
    input  logic             o_end_marker,
    input  logic [CNT_W-1:0] o_peak_count,
    input  logic             o_overflow,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               mismatches,
    output int               due,
    output int               grids_done,
    output int               peaks_seen,
    output int               overflows_seen
);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_sample          value;
        logic             end_mark;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_peak_rec;

    t_peak_rec   records_due[$];
    t_sample     cell_mem [STORE_DEPTH];
    int unsigned grid_w;
    int unsigned grid_h;
    int unsigned load_pos;
    int unsigned found;
    t_sample     frame_max;
    int          err_count;
    int          end_count;
    int          peak_count;
    int          ovf_count;

    function automatic int unsigned clamp_dim(input logic [8:0] raw, input int unsigned hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return 32'(raw);
    endfunction

    function automatic void restart_frame();
        load_pos  = 0;
        frame_max = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        found     = 0;
    endfunction

    // Stores one sample; when it completes the grid, scans the interior and
    // queues the peak beats followed by the end beat.
    function automatic void take_sample(input t_sample s);
        int unsigned total;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        t_sample     v;
        logic        ovf;
        t_peak_rec   rec;
        total = grid_w * grid_h;
        if (load_pos >= total) restart_frame();
        cell_mem[load_pos] = s;
        if (s > frame_max) frame_max = s;
        load_pos++;
        if (load_pos < total) return;
        ovf = 1'b0;
        for (r = 1; r + 1 < grid_h; r++) begin
            for (c = 1; c + 1 < grid_w; c++) begin
                idx = r * grid_w + c;
                v   = cell_mem[idx];
                if (v < cell_mem[idx-1] || v < cell_mem[idx+1] ||
                    v < cell_mem[idx-grid_w] || v < cell_mem[idx+grid_w])
                    continue;
                if (longint'(v) * 4 <= longint'(frame_max) * 3)
                    continue;
                if (found >= MAX_PEAKS) begin
                    ovf = 1'b1;
                    continue;
                end
                rec = '{row: r[POS_W-1:0], col: c[POS_W-1:0], value: v,
                        end_mark: 1'b0, count: '0, ovf: 1'b0};
                records_due.push_back(rec);
                found++;
            end
        end
        rec = '{row: '0, col: '0, value: '0, end_mark: 1'b1,
                count: found[CNT_W-1:0], ovf: ovf};
        records_due.push_back(rec);
        restart_frame();
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_peak_rec want;
        if (!i_rst_n) begin
            grid_w = clamp_dim(9'd256, MAX_COLS);
            grid_h = clamp_dim(9'd256, MAX_ROWS);
            records_due.delete();
            restart_frame();
        end else begin
            if (o_result_valid) begin
                if (records_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat row %0d col %0d end %0b",
                                            o_peak_row, o_peak_col, o_end_marker));
                end else begin
                    want = records_due.pop_front();
                    if (o_peak_row !== want.row)
                        flag_mismatch($sformatf("row %0d, want %0d", o_peak_row, want.row));
                    if (o_peak_col !== want.col)
                        flag_mismatch($sformatf("col %0d, want %0d", o_peak_col, want.col));
                    if (o_peak_value !== want.value)
                        flag_mismatch($sformatf("value %0d, want %0d",
                                                o_peak_value, want.value));
                    if (o_end_marker !== want.end_mark)
                        flag_mismatch($sformatf("end marker %0b, want %0b",
                                                o_end_marker, want.end_mark));
                    if (o_peak_count !== want.count)
                        flag_mismatch($sformatf("count %0d, want %0d",
                                                o_peak_count, want.count));
                    if (o_overflow !== want.ovf)
                        flag_mismatch($sformatf("overflow %0b, want %0b",
                                                o_overflow, want.ovf));
                    if (want.end_mark) begin
                        end_count++;
                        if (want.ovf) ovf_count++;
                    end else begin
                        peak_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_COLS)
                    grid_w = clamp_dim(pwdata[8:0], MAX_COLS);
                else
                    grid_h = clamp_dim(pwdata[8:0], MAX_ROWS);
                restart_frame();
            end
            if (i_start && !o_busy) take_sample(i_sample);
        end
        mismatches     <= err_count;
        due            <= records_due.size();
        grids_done     <= end_count;
        peaks_seen     <= peak_count;
        overflows_seen <= ovf_count;
    end

endmodule

// File: tb/sv/grid_local_maxima_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_local_maxima_finder_tb: stimulus and verdict for the grid peak finder
// Programs the grid size over the configuration port, loads grids of sample
// beats with random gaps and leaves the checking to the checker beside the
// block. A directed opening covers extreme samples, ties, the threshold edge
// and a restarted load; random grids of many sizes and fill styles follow.
// ----------------------------------------------------------------------------
module grid_local_maxima_finder_tb;
    import glmf_pkg::*;

    localparam int      CYCLE_LIMIT  = 400000;
    localparam int      RANDOM_BEATS = 80;
    // Past this many random beats the sender no longer pauses.
    localparam int      CALM_AFTER   = 55;
    localparam t_sample SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // How the samples of one grid are made up.
    typedef enum logic [2:0] {
        FILL_RANDOM,
        FILL_TIES,
        FILL_NEAR_TOP,
        FILL_FLAT,
        FILL_NEGATIVE
    } t_fill;

    logic             i_clk;
    logic             i_rst_n  = 1'b0;
    logic             i_start  = 1'b0;
    t_sample          i_sample = '0;
    logic             o_busy;
    logic             o_result_valid;
    logic [POS_W-1:0] o_peak_row;
    logic [POS_W-1:0] o_peak_col;
    t_sample          o_peak_value;
    logic             o_end_marker;
    logic [CNT_W-1:0] o_peak_count;
    logic             o_overflow;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [2:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;

    int mismatches;
    int due;
    int grids_done;
    int peaks_seen;
    int overflows_seen;

    int          cycle_count = 0;
    int          sent_beats  = 0;
    int unsigned grid_cols   = 256;
    int unsigned grid_rows   = 256;
    logic        pauses_on   = 1'b1;

    grid_local_maxima_finder dut (.*);

    // The checker sees exactly what the block sees and hands back its
    // mismatch count and the number of result beats still outstanding.
    grid_local_maxima_finder_chk chk (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a missing end beat ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d result beats still due", cycle_count, due);
        $display("grid_local_maxima_finder_tb NOT OK");
        $finish;
    end

    function automatic int unsigned size_of(input logic [8:0] raw, input int unsigned hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return 32'(raw);
    endfunction

    // One register write: setup cycle, then access cycle until pready.
    // The bits above the size field carry noise, which the block drops.
    task automatic write_reg(input logic idx, input logic [8:0] raw);
        logic [31:0] word;
        word      = $urandom();
        word[8:0] = raw;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLS)
            grid_cols = size_of(raw, MAX_COLS);
        else
            grid_rows = size_of(raw, MAX_ROWS);
    endtask

    // Holds one sample beat on the port until the block takes it. Afterwards
    // the sender may go quiet for a random burst; while quiet the sample bus
    // carries junk that must not be picked up.
    task automatic send_sample(input t_sample value);
        i_start  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_busy);
        sent_beats++;
        if (pauses_on && $urandom_range(0, 4) == 0) begin
            i_start  <= 1'b0;
            i_sample <= $urandom();
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every due result beat has come out and
    // the last stored sample has settled, before a register write restarts
    // the load.
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (due != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample(input t_fill fill, input logic [31:0] level);
        int          ofs;
        logic [31:0] bits;
        bits = $urandom();
        case (fill)
            FILL_TIES: begin
                ofs = $urandom_range(0, 6);
                return t_sample'(ofs - 3);
            end
            FILL_NEAR_TOP: begin
                // Mostly a plateau just above the level, with some cells cut
                // to half of it so that the threshold rejects them.
                if ($urandom_range(0, 3) == 0) return t_sample'(level >> 1);
                return t_sample'(level + $urandom_range(0, 15));
            end
            FILL_FLAT:     return t_sample'(level);
            FILL_NEGATIVE: return t_sample'({1'b1, bits[30:0]});
            default:       return t_sample'(bits);
        endcase
    endfunction

    // Sends `count` beats of one fill style: a whole grid, or fewer for a
    // load that is broken off by a register write.
    task automatic send_grid(input t_fill fill, input int unsigned count,
                             input logic [31:0] level);
        repeat (count) send_sample(pick_sample(fill, level));
    endtask

    initial begin : stimulus
        int unsigned total;
        int unsigned random_start;
        t_fill       fill;
        logic [31:0] level;
        logic [8:0]  raw_cols;
        logic [8:0]  raw_rows;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Both sizes are written below the minimum, so the
        // block works on a 3 x 3 grid with one interior cell.
        write_reg(REG_COLS, 9'd0);
        write_reg(REG_ROWS, 9'd2);

        // Largest sample in the middle, most negative everywhere else.
        for (int i = 0; i < 9; i++) send_sample(i == 4 ? SAMPLE_MAX : SAMPLE_MIN);
        // Threshold edge: max 4 in a corner, center 3, and 4*3 > 3*4 fails.
        for (int i = 0; i < 9; i++) send_sample(i == 0 ? 4 : (i == 4 ? 3 : 0));
        // A flat grid: the center ties with all four neighbors.
        for (int i = 0; i < 9; i++) send_sample(SAMPLE_MAX);
        // A load broken off by a register write, which starts the grid over.
        drain();
        send_grid(FILL_RANDOM, 4, '0);
        drain();
        write_reg(REG_COLS, 9'd3);

        // A wide grid, flat and positive: all 64 interior cells are peaks,
        // so the peak limit is reached and the end beat flags overflow.
        drain();
        write_reg(REG_COLS, 9'd66);
        write_reg(REG_ROWS, 9'd3);
        send_grid(FILL_FLAT, grid_cols * grid_rows, 32'h1234_5678);

        // Random part: phases of one size each, a few grids per phase, and
        // now and then a load that is abandoned partway through.
        random_start = sent_beats;
        while (sent_beats - random_start < RANDOM_BEATS) begin
            raw_cols = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(10, 12))
                                                   : 9'($urandom_range(0, 9));
            raw_rows = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(10, 12))
                                                   : 9'($urandom_range(0, 9));
            drain();
            write_reg(REG_COLS, raw_cols);
            write_reg(REG_ROWS, raw_rows);
            repeat ($urandom_range(1, 3)) begin
                pauses_on = (sent_beats - random_start < CALM_AFTER);
                fill      = t_fill'($urandom_range(0, 4));
                level     = (fill == FILL_NEAR_TOP) ? $urandom_range(16, 32'h7FFF_FFF0)
                                                    : $urandom();
                total     = grid_cols * grid_rows;
                if ($urandom_range(0, 7) == 0) begin
                    send_grid(fill, $urandom_range(1, total - 1), level);
                    drain();
                    write_reg(REG_ROWS, 9'($urandom_range(0, 9)));
                end else begin
                    send_grid(fill, total, level);
                end
            end
        end

        // Let the last scan finish, then a little longer for stray beats.
        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d sample beats over %0d grids, %0d peak beats checked",
                 sent_beats, grids_done, peaks_seen);
        $display("%0d scans overflowed the peak limit, %0d mismatches",
                 overflows_seen, mismatches);
        if (mismatches == 0 && due == 0)
            $display("grid_local_maxima_finder_tb OK");
        else
            $display("grid_local_maxima_finder_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/glmf_pkg.sv
rtl/glmf_ram.sv
rtl/glmf_ctrl.sv
rtl/glmf_dpath.sv
rtl/grid_local_maxima_finder.sv
tb/sv/grid_local_maxima_finder_chk.sv
tb/sv/grid_local_maxima_finder_tb.sv
